[design/rtv_pkg.sv]
// Shared codes and defaults for the rank-to-value range map.
package rtv_pkg;

	localparam int MAX_RANGES_DEF = 256;
	localparam int VALUE_BITS_DEF = 48;

	localparam int REQ_BITS    = 2;
	localparam int STATUS_BITS = 3;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_ORDER    = 3'd2,
		ST_NOENTRY  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

endpackage

[design/rank_to_value_range_map.sv]
// Rank-to-value range map: range table, binary-search sequencer and result register.
// Path to out_valid: load S_LD_CHK, S_LD_WR, S_RESP; clear, unused code, empty table or rank
// zero go to S_RESP; query S_Q_RD, S_Q_CMP per probe, last S_Q_RD, S_Q_SUM1, S_Q_SUM2, S_RESP.
// Throughput: one item at a time, in_ready high only while idle, so in_ready returns together
// with the result in out_valid; a result held by out_ready holds the sequencer.
// Reset: arst_n clears count, next rank (to one), last end and handshakes; rows stay undefined.
module rank_to_value_range_map #(
	parameter int MAX_RANGES = rtv_pkg::MAX_RANGES_DEF,
	parameter int VALUE_BITS = rtv_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rtv_pkg::REQ_BITS-1:0]    req_type,
	input  logic [VALUE_BITS-1:0]           range_start,
	input  logic [VALUE_BITS-1:0]           range_end,
	input  logic [VALUE_BITS-1:0]           query_rank,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [VALUE_BITS-1:0]           mapped_value,
	output logic [rtv_pkg::STATUS_BITS-1:0] status
);
	import rtv_pkg::*;

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int V  = VALUE_BITS;

	// one table row: first rank of the range and value-minus-rank offset
	typedef struct packed {
		logic [V-1:0] first;
		logic [V-1:0] offset;
	} entry_t;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LD_CHK  = 8'b0000_0010,
		S_LD_WR   = 8'b0000_0100,
		S_Q_RD    = 8'b0000_1000,
		S_Q_CMP   = 8'b0001_0000,
		S_Q_SUM1  = 8'b0010_0000,
		S_Q_SUM2  = 8'b0100_0000,
		S_RESP    = 8'b1000_0000
	} state_t;

	state_t state_q;

	// table storage
	entry_t mem [MAX_RANGES];
	entry_t rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	entry_t        wr_data;

	// architectural state
	logic [CW-1:0] count_q;
	logic [V:0]    next_rank_q;
	logic [V-1:0]  last_end_q;

	// captured item
	logic [V-1:0] start_in_q;
	logic [V-1:0] end_in_q;
	logic [V-1:0] rank_q;

	// working registers
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic [AW-1:0] mid_q;
	logic [AW-1:0] mid;
	logic [AW:0]   span;
	logic [V:0]    diff_q;
	logic          ord_bad_q;
	logic [V-1:0]  base_q;
	logic [V-1:0]  delta_q;
	logic [V:0]    sum;
	logic [V-1:0]  res_value_q;
	status_t       res_status_q;

	// output register
	logic          out_valid_q;
	logic [V-1:0]  out_value_q;
	status_t       out_status_q;

	logic in_fire;
	logic resp_go;
	logic load_full;
	logic load_ok;

	assign in_ready     = (state_q == S_IDLE);
	assign in_fire      = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign mapped_value = out_value_q;
	assign status       = out_status_q;

	// Result leaves the working registers once the output slot is free.
	assign resp_go = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// Midpoint rounds up so the search converges on the last entry <= rank.
	assign span = {1'b0, hi_q} - {1'b0, lo_q} + (AW+1)'(1);
	assign mid  = lo_q + span[AW:1];

	// Once the window closes, fetch the survivor for the final add.
	assign rd_addr = (lo_q == hi_q) ? lo_q : mid;

	assign load_full = (count_q == CW'(MAX_RANGES));
	assign load_ok   = !load_full && !diff_q[V] && !ord_bad_q && !next_rank_q[V];
	assign wr_en     = (state_q == S_LD_WR) && load_ok;
	assign wr_data   = '{first: next_rank_q[V-1:0], offset: start_in_q - next_rank_q[V-1:0]};

	assign sum = {1'b0, base_q} + {1'b0, delta_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			start_in_q <= range_start;
			end_in_q   <= range_end;
			rank_q     <= query_rank;
		end
		if (state_q == S_LD_CHK) begin
			// borrow out of the subtract flags an empty range
			diff_q    <= {1'b0, end_in_q} - {1'b0, start_in_q};
			ord_bad_q <= (count_q != '0) && (start_in_q <= last_end_q);
		end
		if (state_q == S_Q_SUM1) begin
			base_q  <= rd_q.first + rd_q.offset;
			delta_q <= rank_q - rd_q.first;
		end
		if (state_q == S_Q_RD) begin
			mid_q <= mid;
		end
		if (resp_go) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			next_rank_q  <= (V+1)'(1);
			last_end_q   <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (out_valid_q && out_ready && !resp_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_value_q <= '0;
						unique case (req_type)
							REQ_LOAD: begin
								res_status_q <= ST_OK;
								state_q      <= S_LD_CHK;
							end
							REQ_QUERY: begin
								lo_q <= '0;
								hi_q <= AW'(count_q - CW'(1));
								if (count_q == '0 || query_rank == '0) begin
									res_status_q <= ST_NOENTRY;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_Q_RD;
								end
							end
							REQ_CLEAR: begin
								res_status_q <= ST_OK;
								count_q      <= '0;
								next_rank_q  <= (V+1)'(1);
								last_end_q   <= '0;
								state_q      <= S_RESP;
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_LD_CHK: begin
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					// full beats order, order beats rank overflow
					if (load_full) begin
						res_status_q <= ST_FULL;
					end else if (diff_q[V] || ord_bad_q) begin
						res_status_q <= ST_ORDER;
					end else if (next_rank_q[V]) begin
						res_status_q <= ST_OVERFLOW;
					end else begin
						count_q     <= count_q + CW'(1);
						next_rank_q <= next_rank_q + {1'b0, diff_q[V-1:0]} + (V+1)'(1);
						last_end_q  <= end_in_q;
					end
					state_q <= S_RESP;
				end
				S_Q_RD: begin
					state_q <= (lo_q == hi_q) ? S_Q_SUM1 : S_Q_CMP;
				end
				S_Q_CMP: begin
					if (rd_q.first <= rank_q) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - AW'(1);
					end
					state_q <= S_Q_RD;
				end
				S_Q_SUM1: begin
					state_q <= S_Q_SUM2;
				end
				S_Q_SUM2: begin
					// carry out means the value runs past the top of the value field
					if (sum[V]) begin
						res_status_q <= ST_OVERFLOW;
					end else begin
						res_value_q <= sum[V-1:0];
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the rank-to-value range map: stimulus, prediction and checks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rtv_pkg::*;

	localparam int VB = VALUE_BITS_DEF;
	localparam int MAX_R = MAX_RANGES_DEF;
	localparam logic [63:0] VMAX = (64'd1 << VB) - 64'd1;
	// request code that the block must answer with a plain ok
	localparam logic [REQ_BITS-1:0] REQ_SPARE = 2'd3;
	localparam int ITEM_TARGET = 650;
	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [VB-1:0] value;
		status_t       code;
	} answer_t;

	// Predicts the answer of each accepted item and checks results against them in order.
	class range_map_scoreboard;
		logic [VB-1:0] first_rank [MAX_R];
		logic [VB-1:0] offset [MAX_R];
		int unsigned   used;
		logic [VB:0]   next_rank;
		logic [VB-1:0] last_end;
		answer_t       answers [$];
		int            errors;

		function new();
			empty_map();
			errors = 0;
		endfunction

		function void empty_map();
			used = 0;
			next_rank = (VB+1)'(1);
			last_end = '0;
		endfunction

		function int outstanding();
			return answers.size();
		endfunction

		function void note_item(logic [REQ_BITS-1:0] rq, logic [VB-1:0] s, logic [VB-1:0] e,
				logic [VB-1:0] r);
			answer_t       a;
			int            k;
			logic [VB-1:0] start_val;
			logic [VB-1:0] delta;
			logic [63:0]   sum;
			a.value = '0;
			a.code = ST_OK;
			case (rq)
				REQ_LOAD: begin
					if (used == MAX_R)
						a.code = ST_FULL;
					else if (e < s || (used != 0 && s <= last_end))
						a.code = ST_ORDER;
					else if (next_rank[VB])
						a.code = ST_OVERFLOW;
					else begin
						first_rank[used] = next_rank[VB-1:0];
						offset[used] = s - next_rank[VB-1:0];
						used++;
						next_rank = next_rank + e - s + 1;
						last_end = e;
					end
				end
				REQ_QUERY: begin
					if (used == 0 || r == 0)
						a.code = ST_NOENTRY;
					else begin
						// first ranks ascend and entry zero starts at rank one
						k = used - 1;
						while (first_rank[k] > r)
							k--;
						start_val = first_rank[k] + offset[k];
						delta = r - first_rank[k];
						sum = 64'(start_val) + 64'(delta);
						if (sum > VMAX)
							a.code = ST_OVERFLOW;
						else
							a.value = sum[VB-1:0];
					end
				end
				REQ_CLEAR: empty_map();
				default: ;
			endcase
			answers.insert(answers.size(), a);
		endfunction

		function void check_result(logic [VB-1:0] v, logic [STATUS_BITS-1:0] st);
			answer_t a;
			if (answers.size() == 0) begin
				$error("result with no item waiting: mapped_value %0h status %0d", v, st);
				errors++;
				return;
			end
			a = answers.pop_front();
			if (v !== a.value) begin
				$error("mapped_value: expected %0h, actual %0h", a.value, v);
				errors++;
			end
			if (st !== a.code) begin
				$error("status: expected %0d, actual %0d", a.code, st);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [REQ_BITS-1:0]    req_type;
	logic [VB-1:0]          range_start;
	logic [VB-1:0]          range_end;
	logic [VB-1:0]          query_rank;
	logic                   out_valid;
	logic                   out_ready;
	logic [VB-1:0]          mapped_value;
	logic [STATUS_BITS-1:0] status;

	range_map_scoreboard sb = new();

	bit          in_fire = 1'b0;
	bit          out_fire = 1'b0;
	bit          gaps_on = 1'b1;
	bit          stall_on = 1'b1;
	bit          long_hold = 1'b0;
	int          n_sent = 0;
	// placement of the current load sequence
	logic [63:0] seq_base;
	logic [63:0] gap_cap;
	logic [63:0] len_cap;

	rank_to_value_range_map u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.range_start(range_start),
		.range_end(range_end),
		.query_rank(query_rank),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mapped_value(mapped_value),
		.status(status)
	);

	always #6 clk = ~clk;

	// Sample both handshakes on the falling edge before the rising edge that completes them:
	// inputs and flops only move on the rising edge, so these values hold until then.
	always @(negedge clk) begin
		in_fire = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		if (in_fire)
			sb.note_item(req_type, range_start, range_end, query_rank);
		if (out_fire)
			sb.check_result(mapped_value, status);
	end

	// End the run when nothing moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (in_fire || out_fire)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL rank_to_value_range_map");
				$finish;
			end
		end
	end

	// Result side: short random stalls, plus one long hold-off on request so the
	// block backs up and drops in_ready while the sender keeps offering.
	initial begin : drain_results
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	function automatic logic [VB-1:0] rand_value();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[VB-1:0];
	endfunction

	// uniform-ish value in [0, lim-1]; zero when lim is zero
	function automatic logic [63:0] pick_below(logic [63:0] lim);
		logic [63:0] w;
		w = {$urandom, $urandom};
		if (lim == 0)
			return 0;
		return w % lim;
	endfunction

	// Favor ranks inside the loaded total, hit entry boundaries, and sometimes
	// go past the end, to zero, or anywhere in the field.
	function automatic logic [VB-1:0] pick_rank();
		logic [63:0] total;
		logic [63:0] w;
		total = 64'(sb.next_rank) - 64'd1;
		case ($urandom_range(0, 9))
			0: w = 0;
			1: w = 64'(rand_value());
			2: w = total + $urandom_range(1, 64);
			3: begin
				if (sb.used != 0)
					w = 64'(sb.first_rank[$urandom_range(0, sb.used - 1)]) - $urandom_range(0, 1);
				else
					w = $urandom_range(0, 8);
			end
			default: w = (total == 0) ? 64'($urandom_range(1, 8)) : 64'd1 + pick_below(total);
		endcase
		if (w > VMAX)
			w = VMAX;
		return w[VB-1:0];
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic offer(input logic [REQ_BITS-1:0] rq, input logic [VB-1:0] s,
			input logic [VB-1:0] e, input logic [VB-1:0] r);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		range_start <= s;
		range_end <= e;
		query_rank <= r;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		n_sent++;
	endtask

	// Drop valid and wait until every predicted result has been checked.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Append the next ascending range; when it would run off the top of the
	// value field, send a random load instead.
	task automatic load_next();
		logic [63:0] s;
		logic [63:0] e;
		if (sb.used == 0)
			s = seq_base + pick_below(gap_cap);
		else
			s = 64'(sb.last_end) + 64'd1 + pick_below(gap_cap);
		e = s + pick_below(len_cap);
		if (e > VMAX)
			offer(REQ_LOAD, rand_value(), rand_value(), rand_value());
		else
			offer(REQ_LOAD, s[VB-1:0], e[VB-1:0], rand_value());
	endtask

	initial begin : stimulus
		logic [VB-1:0] top;
		int            steps;
		int            pick;
		top = VMAX[VB-1:0];
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		range_start = '0;
		range_end = '0;
		query_rank = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, bad ranges, boundaries, extension past the end,
		// overflow of results and of ranks, the spare code and clears.
		offer(REQ_QUERY, '0, '0, 48'd5);
		offer(REQ_LOAD, 48'd20, 48'd10, '0);
		offer(REQ_LOAD, 48'd0, 48'd0, '0);
		offer(REQ_LOAD, 48'd0, 48'd5, '0);
		offer(REQ_LOAD, 48'd10, 48'd19, '0);
		offer(REQ_QUERY, '0, '0, 48'd0);
		offer(REQ_QUERY, '0, '0, 48'd1);
		offer(REQ_QUERY, '0, '0, 48'd2);
		offer(REQ_QUERY, '0, '0, 48'd11);
		offer(REQ_QUERY, '0, '0, 48'd12);
		offer(REQ_QUERY, '0, '0, top);
		offer(REQ_SPARE, top, top, top);
		offer(REQ_CLEAR, top, top, top);
		offer(REQ_QUERY, '0, '0, 48'd1);
		offer(REQ_LOAD, top - 48'd5, top, '0);
		offer(REQ_QUERY, '0, '0, 48'd6);
		offer(REQ_QUERY, '0, '0, 48'd7);
		offer(REQ_CLEAR, '0, '0, '0);
		offer(REQ_LOAD, 48'd0, top - 48'd1, '0);
		offer(REQ_QUERY, '0, '0, top);
		offer(REQ_LOAD, top, top, '0);
		offer(REQ_CLEAR, '0, '0, '0);
		offer(REQ_LOAD, top, top, '0);
		offer(REQ_QUERY, '0, '0, 48'd1);
		offer(REQ_QUERY, '0, '0, 48'd2);

		// Pause the sender until the block has answered everything.
		wait_drained();

		// Fill the table to the last entry, then push loads against the full table.
		seq_base = 64'($urandom);
		gap_cap = 64'd1024;
		len_cap = 64'd4096;
		offer(REQ_CLEAR, rand_value(), rand_value(), rand_value());
		for (int i = 0; i < MAX_R; i++) begin
			if (i == 120)
				long_hold = 1'b1;
			load_next();
			if (i % 20 == 7)
				offer(REQ_QUERY, rand_value(), rand_value(), pick_rank());
		end
		load_next();
		load_next();
		offer(REQ_LOAD, 48'd5, 48'd1, rand_value());
		repeat (30)
			offer(REQ_QUERY, rand_value(), rand_value(), pick_rank());
		wait_drained();

		// Random sequences: mostly ascending loads and queries from a fresh table,
		// some random items mixed in.
		while (n_sent < ITEM_TARGET) begin
			if (n_sent > ITEM_TARGET - 90) begin
				gaps_on = 1'b0;
				stall_on = 1'b0;
			end else begin
				gaps_on = $urandom_range(0, 3) != 0;
				stall_on = $urandom_range(0, 3) != 0;
			end
			case ($urandom_range(0, 3))
				0: seq_base = 0;
				1: seq_base = 64'($urandom);
				2: seq_base = 64'(rand_value()) >> 1;
				default: seq_base = VMAX - pick_below(64'd1 << 24);
			endcase
			case ($urandom_range(0, 3))
				0: gap_cap = 64'd1;
				1: gap_cap = 64'd8;
				2: gap_cap = 64'd1 << 16;
				default: gap_cap = 64'd1 << 40;
			endcase
			case ($urandom_range(0, 3))
				0: len_cap = 64'd1;
				1: len_cap = 64'd16;
				2: len_cap = 64'd1 << 20;
				default: len_cap = 64'd1 << 44;
			endcase
			offer(REQ_CLEAR, rand_value(), rand_value(), rand_value());
			steps = $urandom_range(4, 30);
			repeat (steps) begin
				pick = $urandom_range(0, 19);
				if (pick < 11)
					load_next();
				else if (pick < 18)
					offer(REQ_QUERY, rand_value(), rand_value(), pick_rank());
				else
					offer(REQ_BITS'($urandom_range(0, 3)), rand_value(), rand_value(),
						rand_value());
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS rank_to_value_range_map");
		else
			$display("FAIL rank_to_value_range_map");
		$finish;
	end

endmodule

[rank_to_value_range_map.f]
design/rtv_pkg.sv
design/rank_to_value_range_map.sv
tb/sv/testbench.sv
